// ----- src/dxt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT block decoder package
// Register indexes, format codes, palette types and the small arithmetic
// helpers (RGB565 expansion, division by constants) used by the decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // Block format codes; the spare code decodes as DXT1
  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  localparam int unsigned CntW    = 14;
  localparam int unsigned BlkW    = CntW + 1;
  localparam int unsigned TexelsW = 32;
  localparam int unsigned RowsPerBlock = 4;

  // Reciprocal multipliers, exact over the operand ranges used here
  localparam int unsigned DIV6_MUL   = 683;   // x < 2048, shift 12
  localparam int unsigned DIV14_MUL  = 4682;  // x < 4096, shift 16
  localparam int unsigned DIV5_MUL   = 1639;  // x < 2048, shift 13

  typedef logic [7:0]      chan_t;
  typedef chan_t [2:0]     rgb_t;    // [0] R, [1] G, [2] B
  typedef logic [TexelsW-1:0] texel_t;

  // Expand RGB565 to 8 bits per channel by bit replication
  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e[0] = {c[15:11], c[15:13]};
    e[1] = {c[10:5], c[10:9]};
    e[2] = {c[4:0], c[4:2]};
    return e;
  endfunction

  // x / 6 for x < 2048
  function automatic chan_t div6(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(DIV6_MUL);
    return p[19:12];
  endfunction

  // x / 14 for x < 4096
  function automatic chan_t div14(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV14_MUL);
    return p[23:16];
  endfunction

  // x / 5 for x < 2048
  function automatic chan_t div5(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(DIV5_MUL);
    return p[20:13];
  endfunction

  // Blocks covering a pixel extent; an extent of zero counts as one block
  function automatic logic [BlkW-1:0] blocks_of(input logic [15:0] px);
    logic [16:0] n;
    n = (17'(px) + 17'd3) >> 2;
    return (n == 17'd0) ? BlkW'(1) : n[BlkW-1:0];
  endfunction

endpackage

// ----- src/dxt_block_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DXT block decoder
// Decodes DXT1 / DXT3 / DXT5 4x4 blocks into four RGBA8888 texel rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one compressed block per
//   beat: alpha_half_i holds block bytes 0..7, color_half_i bytes 8..15.
//   Output channel (out_valid_o / out_stall_i) gives four beats per block,
//   top texel row first, each with four pixels and the row start coordinates.
//   An accepted block is held in the block register, and its rows move in
//   order into the output register whenever the receiver does not stall.
//   The single output channel carries one row a beat. A new block is taken
//   at the edge the last row of the current one moves into the output
//   register, so blocks stream back to back with no gap.
//   A stall on the output holds the output register and the block register;
//   the input stalls while the block register holds a block whose last row
//   cannot move on, so at most one block waits behind the output register.
//   Configuration writes land at once; write only while the block is idle.
//   Reset clears the counters, selects DXT1 and a 4x4 image, and empties
//   both registers. Column and row block counters walk the image in raster
//   order and wrap to zero after the last block.
// ----------------------------------------------------------------------------
module dxt_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // compressed block input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] alpha_half_i,
  input  logic [63:0] color_half_i,
  // texel row output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output dxt_pkg::texel_t texel_0_o,
  output dxt_pkg::texel_t texel_1_o,
  output dxt_pkg::texel_t texel_2_o,
  output dxt_pkg::texel_t texel_3_o,
  output logic        row_last_o,
  output logic        image_last_o
);
  import dxt_pkg::*;

  // configuration registers
  logic [1:0]  fmt_q;
  logic [15:0] width_q, height_q;

  // block counters
  logic [CntW-1:0] col_q, col_d, row_q, row_d;

  // block register
  logic            blk_vld_q, blk_vld_d;
  logic [1:0]      sub_q, sub_d;
  logic [63:0]     alpha_q, color_q;
  logic [CntW-1:0] blk_col_q, blk_row_q;
  logic            blk_last_q;

  // output register
  logic        out_vld_q, out_vld_d;
  logic [15:0] out_x_q, out_y_q;
  texel_t      texel_q [RowsPerBlock];
  texel_t      texel_d [RowsPerBlock];
  logic        row_last_q, image_last_q;

  logic in_acc, adv, last_sub;
  logic [BlkW-1:0] bpr, brows;
  logic col_end, row_end;

  // decode signals
  logic        is_dxt3, is_dxt5, three;
  rgb_t        e0, e1;
  chan_t       pal [4][3];
  chan_t       apal [8];
  logic [11:0] s14 [6];
  logic [10:0] s5 [4];
  logic [7:0]  crow;
  logic [15:0] arow3;
  logic [11:0] arow5;
  logic [1:0]  ci;
  chan_t       a;

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign adv        = !out_vld_q || !out_stall_i;
  assign last_sub   = (sub_q == 2'd3);
  assign in_stall_o = blk_vld_q && !(adv && last_sub);
  assign in_acc     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_DXT1;
      width_q  <= 16'd4;
      height_q <= 16'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORMAT: fmt_q    <= cfg_data_i[1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // block position: wrap the column at the row end, the row at the image end
  // --------------------------------------------------------------------------
  assign bpr     = blocks_of(width_q);
  assign brows   = blocks_of(height_q);
  assign col_end = (BlkW'(col_q) + BlkW'(1)) >= bpr;
  assign row_end = (BlkW'(row_q) + BlkW'(1)) >= brows;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // block register control: issue one row a beat
  // --------------------------------------------------------------------------
  always_comb begin
    blk_vld_d = blk_vld_q;
    sub_d     = sub_q;
    if (adv && blk_vld_q) begin
      sub_d = sub_q + 2'd1;
      if (last_sub) begin
        blk_vld_d = 1'b0;
      end
    end
    if (in_acc) begin
      blk_vld_d = 1'b1;
      sub_d     = 2'd0;
    end
    out_vld_d = adv ? blk_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= 1'b0;
      sub_q     <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      blk_vld_q <= blk_vld_d;
      sub_q     <= sub_d;
      out_vld_q <= out_vld_d;
    end
  end

  // capture the block beat and its position
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      alpha_q    <= alpha_half_i;
      color_q    <= color_half_i;
      blk_col_q  <= col_q;
      blk_row_q  <= row_q;
      blk_last_q <= col_end && row_end;
    end
  end

  // --------------------------------------------------------------------------
  // palettes
  // --------------------------------------------------------------------------
  always_comb begin
    is_dxt3 = (fmt_q == FMT_DXT3);
    is_dxt5 = (fmt_q == FMT_DXT5);
    three   = !is_dxt3 && !is_dxt5 && (color_q[15:0] <= color_q[31:16]);
    e0      = expand565(color_q[15:0]);
    e1      = expand565(color_q[31:16]);

    // colour entries; three-colour mode averages and blacks out index 3
    for (int k = 0; k < 3; k++) begin
      pal[0][k] = e0[k];
      pal[1][k] = e1[k];
      if (three) begin
        pal[2][k] = chan_t'((9'(e0[k]) + 9'(e1[k])) >> 1);
        pal[3][k] = '0;
      end else begin
        pal[2][k] = div6(11'({e0[k], 2'b00}) + 11'({e1[k], 1'b0}) + 11'd3);
        pal[3][k] = div6(11'({e0[k], 1'b0}) + 11'({e1[k], 2'b00}) + 11'd3);
      end
    end

    // interpolated alpha entries
    for (int i = 0; i < 6; i++) begin
      s14[i] = 12'(alpha_q[7:0]) * 12'(12 - 2 * i)
             + 12'(alpha_q[15:8]) * 12'(2 + 2 * i) + 12'd7;
    end
    for (int i = 0; i < 4; i++) begin
      s5[i] = 11'(alpha_q[7:0]) * 11'(4 - i)
            + 11'(alpha_q[15:8]) * 11'(1 + i) + 11'd2;
    end
    apal[0] = alpha_q[7:0];
    apal[1] = alpha_q[15:8];
    if (alpha_q[7:0] > alpha_q[15:8]) begin
      for (int i = 0; i < 6; i++) begin
        apal[2 + i] = div14(s14[i]);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        apal[2 + i] = div5(s5[i]);
      end
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end
  end

  // --------------------------------------------------------------------------
  // select the current texel row
  // --------------------------------------------------------------------------
  always_comb begin
    crow  = color_q[32 + 8 * int'(sub_q) +: 8];
    arow3 = alpha_q[16 * int'(sub_q) +: 16];
    arow5 = alpha_q[16 + 12 * int'(sub_q) +: 12];
    ci    = '0;
    a     = '0;
    for (int k = 0; k < 4; k++) begin
      ci = crow[2 * k +: 2];
      case (fmt_q)
        FMT_DXT3: a = {arow3[4 * k +: 4], arow3[4 * k +: 4]};
        FMT_DXT5: a = apal[arow5[3 * k +: 3]];
        default:  a = (three && ci == 2'd3) ? 8'd0 : 8'd255;
      endcase
      texel_d[k] = {a, pal[ci][2], pal[ci][1], pal[ci][0]};
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv && blk_vld_q) begin
      out_x_q      <= {blk_col_q, 2'b00};
      out_y_q      <= {blk_row_q, sub_q};
      texel_q      <= texel_d;
      row_last_q   <= last_sub;
      image_last_q <= last_sub && blk_last_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign texel_0_o    = texel_q[0];
  assign texel_1_o    = texel_q[1];
  assign texel_2_o    = texel_q[2];
  assign texel_3_o    = texel_q[3];
  assign row_last_o   = row_last_q;
  assign image_last_o = image_last_q;

`ifndef NO_ASSERTIONS
  // an accepted block starts issuing from its top row
  a_accept_starts_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (blk_vld_q && sub_q == 2'd0))
    else $error("accepted block did not start at its top row");

  // the fourth row of a block is flagged and only that one
  a_row_last_matches_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (row_last_o == (pixel_y_o[1:0] == 2'd3)))
    else $error("row_last does not match the texel row");

  // image end falls on a block end
  a_image_last_on_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_last_o) |-> row_last_o)
    else $error("image_last raised off the last row of a block");
`endif

endmodule
